/* sv/iskscan_pkg.sv */
`timescale 1ns / 1ps

package iskscan_pkg;

    localparam int OUT_VALUE_WIDTH = 32;
    localparam int M_TDATA_WIDTH   = 136;
    localparam int KEY_COUNT       = 5;
    localparam int NUM_KEY_COUNT   = 4;

    // key index: numeric keys first, Supported last
    localparam logic [2:0] KEY_RANK        = 3'd0;
    localparam logic [2:0] KEY_RATING      = 3'd1;
    localparam logic [2:0] KEY_COLOR_LABEL = 3'd2;
    localparam logic [2:0] KEY_PICK_LABEL  = 3'd3;
    localparam logic [2:0] KEY_SUPPORTED   = 3'd4;

    localparam logic [1:0] SUP_UNKNOWN = 2'd0;
    localparam logic [1:0] SUP_FALSE   = 2'd1;
    localparam logic [1:0] SUP_TRUE    = 2'd2;

    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0b;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_EQUALS = 8'h3d;
    localparam logic [7:0] CH_LBRACK = 8'h5b;

    localparam logic [3:0] HDR_LEN  = 4'd9;
    localparam logic [3:0] TRUE_LEN = 4'd4;
    localparam logic [3:0] POS_MAX  = 4'd15;

    localparam logic [7:0] HDR_TEXT [9] = '{
        8'h5b, 8'h47, 8'h65, 8'h6e, 8'h65, 8'h72, 8'h61, 8'h6c, 8'h5d
    };

    localparam logic [7:0] TRUE_TEXT [4] = '{8'h74, 8'h72, 8'h75, 8'h65};

    localparam logic [3:0] KEY_LEN [KEY_COUNT] = '{4'd4, 4'd6, 4'd10, 4'd9, 4'd9};

    // Rank, Rating, ColorLabel, PickLabel, Supported
    localparam logic [7:0] KEY_TEXT [KEY_COUNT][10] = '{
        '{8'h52, 8'h61, 8'h6e, 8'h6b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h52, 8'h61, 8'h74, 8'h69, 8'h6e, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h43, 8'h6f, 8'h6c, 8'h6f, 8'h72, 8'h4c, 8'h61, 8'h62, 8'h65, 8'h6c},
        '{8'h50, 8'h69, 8'h63, 8'h6b, 8'h4c, 8'h61, 8'h62, 8'h65, 8'h6c, 8'h00},
        '{8'h53, 8'h75, 8'h70, 8'h70, 8'h6f, 8'h72, 8'h74, 8'h65, 8'h64, 8'h00}
    };

    typedef enum logic [6:0] {
        PH_START  = 7'b0000001,
        PH_HEADER = 7'b0000010,
        PH_KEY    = 7'b0000100,
        PH_BLANK  = 7'b0001000,
        PH_DIGITS = 7'b0010000,
        PH_TRUE   = 7'b0100000,
        PH_SKIP   = 7'b1000000
    } iskscan_phase_t;

    typedef struct packed {
        logic                     section_found;
        logic                     pick_seen;
        logic [1:0]               supported;
        logic [NUM_KEY_COUNT-1:0] neg;
    } iskscan_flags_t;

    function automatic logic [7:0] key_char(input logic [2:0] k, input logic [3:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (k < 3'(KEY_COUNT) && pos < 4'd10)
        begin
            ch = KEY_TEXT[k][pos];
        end
        return ch;
    endfunction

endpackage

/* sv/iskscan_parse.sv */
`timescale 1ns / 1ps

module iskscan_parse
    import iskscan_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    step,
    input  logic [7:0]                              text_byte,
    input  logic                                    end_of_text,
    output logic                                    result_load,
    output iskscan_flags_t                          result_flags,
    output logic [NUM_KEY_COUNT-1:0][VALUE_WIDTH-1:0] result_mag
);

    localparam int PW = VALUE_WIDTH + 4;
    localparam logic [VALUE_WIDTH-1:0] VALUE_CAP = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic [VALUE_WIDTH-1:0] MAG_ONE   = {{(VALUE_WIDTH-1){1'b0}}, 1'b1};

    iskscan_phase_t                           phase_reg, phase_next;
    logic                                     in_section_reg, in_section_next;
    logic                                     seen_reg, seen_next;
    logic                                     finished_reg, finished_next;
    logic [KEY_COUNT-1:0]                     cand_reg, cand_next;
    logic [3:0]                               pos_reg, pos_next;
    logic [1:0]                               target_reg, target_next;
    logic [VALUE_WIDTH-1:0]                   acc_reg, acc_next;
    logic                                     neg_reg, neg_next;
    logic [NUM_KEY_COUNT-1:0][VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [NUM_KEY_COUNT-1:0]                 sneg_reg, sneg_next;
    logic                                     pick_reg, pick_next;
    logic [1:0]                               sup_reg, sup_next;

    logic [PW-1:0]          prod;
    logic [VALUE_WIDTH-1:0] acc_digit;
    logic                   is_digit;
    logic                   is_blank;
    logic [KEY_COUNT-1:0]   k_cand;
    logic [3:0]             k_pos;
    logic [KEY_COUNT-1:0]   chr_hit;
    logic [KEY_COUNT-1:0]   eq_hit;
    logic [2:0]             eq_key;
    logic                   do_key;
    logic                   do_write;

    always_comb
    begin
        is_digit  = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
        is_blank  = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                    (text_byte == CH_VT) || (text_byte == CH_FF);
        // acc * 10 + digit, clipped at the magnitude cap
        prod      = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + PW'(text_byte[3:0]);
        acc_digit = (prod > PW'(VALUE_CAP)) ? VALUE_CAP : prod[VALUE_WIDTH-1:0];

        k_cand = (phase_reg == PH_START) ? {KEY_COUNT{1'b1}} : cand_reg;
        k_pos  = (phase_reg == PH_START) ? 4'd0 : pos_reg;
        eq_key = 3'd0;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            chr_hit[k] = k_cand[k] && (k_pos < KEY_LEN[k]) &&
                         (text_byte == key_char(3'(k), k_pos));
            eq_hit[k]  = k_cand[k] && (k_pos == KEY_LEN[k]) && (text_byte == CH_EQUALS);
        end
        for (int k = KEY_COUNT - 1; k >= 0; k--)
        begin
            if (eq_hit[k])
            begin
                eq_key = 3'(k);
            end
        end

        phase_next      = phase_reg;
        in_section_next = in_section_reg;
        seen_next       = seen_reg;
        finished_next   = finished_reg;
        cand_next       = cand_reg;
        pos_next        = pos_reg;
        target_next     = target_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        sneg_next       = sneg_reg;
        pick_next       = pick_reg;
        sup_next        = sup_reg;
        do_key          = 1'b0;
        do_write        = 1'b0;

        if (!finished_reg)
        begin
            if (text_byte == CH_LF || text_byte == CH_CR)
            begin
                phase_next = PH_START;
            end
            else
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        if (text_byte == CH_LBRACK)
                        begin
                            if (in_section_reg)
                            begin
                                finished_next = 1'b1;
                            end
                            else
                            begin
                                pos_next   = 4'd1;
                                phase_next = PH_HEADER;
                            end
                        end
                        else if (in_section_reg)
                        begin
                            do_key = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_HEADER:
                    begin
                        if (pos_reg < HDR_LEN && text_byte == HDR_TEXT[pos_reg])
                        begin
                            pos_next = pos_reg + 4'd1;
                            if (pos_reg + 4'd1 == HDR_LEN)
                            begin
                                in_section_next = 1'b1;
                                seen_next       = 1'b1;
                                phase_next      = PH_SKIP;
                            end
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_KEY:
                    begin
                        do_key = 1'b1;
                    end
                    PH_BLANK:
                    begin
                        if (is_blank)
                        begin
                            phase_next = PH_BLANK;
                        end
                        else if (text_byte == CH_PLUS || text_byte == CH_MINUS)
                        begin
                            neg_next   = (text_byte == CH_MINUS);
                            do_write   = 1'b1;
                            phase_next = PH_DIGITS;
                        end
                        else if (is_digit)
                        begin
                            acc_next   = acc_digit;
                            do_write   = 1'b1;
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            acc_next = acc_digit;
                            do_write = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_TRUE:
                    begin
                        if (pos_reg < TRUE_LEN && text_byte == TRUE_TEXT[pos_reg[1:0]])
                        begin
                            pos_next = pos_reg + 4'd1;
                            if (pos_reg + 4'd1 == TRUE_LEN)
                            begin
                                sup_next   = SUP_TRUE;
                                phase_next = PH_SKIP;
                            end
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        phase_next = PH_SKIP;
                    end
                    default:
                    begin
                        phase_next = PH_SKIP;
                    end
                endcase
            end
        end

        if (do_key)
        begin
            if (eq_hit != '0)
            begin
                if (eq_key == KEY_SUPPORTED)
                begin
                    sup_next   = SUP_FALSE;
                    pos_next   = 4'd0;
                    phase_next = PH_TRUE;
                end
                else
                begin
                    target_next = eq_key[1:0];
                    acc_next    = '0;
                    neg_next    = 1'b0;
                    if (eq_key == KEY_PICK_LABEL)
                    begin
                        pick_next = 1'b1;
                    end
                    do_write   = 1'b1;
                    phase_next = PH_BLANK;
                end
            end
            else
            begin
                cand_next = chr_hit;
                if (chr_hit != '0)
                begin
                    pos_next   = (k_pos == POS_MAX) ? POS_MAX : k_pos + 4'd1;
                    phase_next = PH_KEY;
                end
                else
                begin
                    pos_next   = k_pos;
                    phase_next = PH_SKIP;
                end
            end
        end

        if (do_write)
        begin
            mag_next[target_next]  = acc_next;
            sneg_next[target_next] = neg_next;
        end
    end

    assign result_load                = step && end_of_text;
    assign result_flags.section_found = seen_next;
    assign result_flags.pick_seen     = pick_next;
    assign result_flags.supported     = sup_next;
    assign result_flags.neg           = sneg_next;
    assign result_mag                 = mag_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START;
            in_section_reg <= 1'b0;
            seen_reg       <= 1'b0;
            finished_reg   <= 1'b0;
            cand_reg       <= {KEY_COUNT{1'b1}};
            pos_reg        <= 4'd0;
            target_reg     <= 2'd0;
            acc_reg        <= '0;
            neg_reg        <= 1'b0;
            mag_reg        <= {{VALUE_WIDTH{1'b0}}, MAG_ONE, MAG_ONE, MAG_ONE};
            sneg_reg       <= 4'b0111;
            pick_reg       <= 1'b0;
            sup_reg        <= SUP_UNKNOWN;
        end
        else if (step && end_of_text)
        begin
            phase_reg      <= PH_START;
            in_section_reg <= 1'b0;
            seen_reg       <= 1'b0;
            finished_reg   <= 1'b0;
            cand_reg       <= {KEY_COUNT{1'b1}};
            pos_reg        <= 4'd0;
            target_reg     <= 2'd0;
            acc_reg        <= '0;
            neg_reg        <= 1'b0;
            mag_reg        <= {{VALUE_WIDTH{1'b0}}, MAG_ONE, MAG_ONE, MAG_ONE};
            sneg_reg       <= 4'b0111;
            pick_reg       <= 1'b0;
            sup_reg        <= SUP_UNKNOWN;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            in_section_reg <= in_section_next;
            seen_reg       <= seen_next;
            finished_reg   <= finished_next;
            cand_reg       <= cand_next;
            pos_reg        <= pos_next;
            target_reg     <= target_next;
            acc_reg        <= acc_next;
            neg_reg        <= neg_next;
            mag_reg        <= mag_next;
            sneg_reg       <= sneg_next;
            pick_reg       <= pick_next;
            sup_reg        <= sup_next;
        end
    end

endmodule

/* sv/iskscan_out.sv */
`timescale 1ns / 1ps

module iskscan_out
    import iskscan_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    load,
    input  iskscan_flags_t                          load_flags,
    input  logic [NUM_KEY_COUNT-1:0][VALUE_WIDTH-1:0] load_mag,
    output logic                                    can_load,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [M_TDATA_WIDTH-1:0]                m_axis_tdata
);

    localparam logic [VALUE_WIDTH-1:0] MAX_POS = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    logic                                     valid_reg, valid_next;
    iskscan_flags_t                           flags_reg;
    logic [NUM_KEY_COUNT-1:0][VALUE_WIDTH-1:0] mag_reg;

    logic signed [VALUE_WIDTH-1:0]            sval [NUM_KEY_COUNT];
    logic [NUM_KEY_COUNT-1:0][OUT_VALUE_WIDTH-1:0] oval;
    logic [OUT_VALUE_WIDTH-1:0]               pick_out;

    assign can_load = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            flags_reg <= load_flags;
            mag_reg   <= load_mag;
        end
    end

    // magnitude + sign to saturated two's complement, then to output width
    always_comb
    begin
        for (int i = 0; i < NUM_KEY_COUNT; i++)
        begin
            if (flags_reg.neg[i])
            begin
                sval[i] = -$signed(mag_reg[i]);
            end
            else
            begin
                sval[i] = mag_reg[i][VALUE_WIDTH-1] ? $signed(MAX_POS) : $signed(mag_reg[i]);
            end
            oval[i] = OUT_VALUE_WIDTH'(sval[i]);
        end
    end

    assign pick_out      = flags_reg.pick_seen ? oval[KEY_PICK_LABEL[1:0]] : '0;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {4'b0,
                            flags_reg.supported,
                            flags_reg.pick_seen,
                            pick_out,
                            oval[KEY_COLOR_LABEL[1:0]],
                            oval[KEY_RATING[1:0]],
                            oval[KEY_RANK[1:0]],
                            flags_reg.section_found};

endmodule

/* sv/ini_section_key_scanner.sv */
`timescale 1ns / 1ps
// ini_section_key_scanner
// Scans keyfile text for the [General] section and its Rank, Rating,
// ColorLabel, PickLabel and Supported keys.
// Input stream: one text byte per word in s_axis_tdata[7:0]; s_axis_tlast
// marks the final byte of a file. Output stream: one word per file, sent
// after the final byte, carrying the section flag and the gathered values.
// Throughput: one byte per cycle while no final byte waits for the result
// register; the per-byte scan into the result register is combinational.
// The result register loads as the final byte leaves the input register.
// If the receiver stalls, the result stays in the output register; bytes
// keep flowing until a second final byte has to wait for that register,
// then s_axis_tready drops until the result is taken.
// Reset clears the scan state and the valid bits of both registers; after
// each result the scan state returns to reset values for the next file.
// VALUE_WIDTH sets the internal saturation width of numbers; values are
// sign-extended or truncated to the 32-bit output fields.

module ini_section_key_scanner
    import iskscan_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,   // text_byte
    input  logic                     s_axis_tlast,   // end_of_text
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // section_found, rank_value, rating_value, color_label_value,
    // pick_label_value, pick_label_seen, supported_state, zero pad
    output logic [M_TDATA_WIDTH-1:0] m_axis_tdata
);

    logic           in_valid_reg, in_valid_next;
    logic [7:0]     in_byte_reg;
    logic           in_last_reg;
    logic           consume;
    logic           can_load;
    logic           result_load;
    iskscan_flags_t result_flags;
    logic [NUM_KEY_COUNT-1:0][VALUE_WIDTH-1:0] result_mag;

    assign consume       = in_valid_reg && (!in_last_reg || can_load);
    assign s_axis_tready = !in_valid_reg || consume;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    iskscan_parse #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (consume),
        .text_byte    (in_byte_reg),
        .end_of_text  (in_last_reg),
        .result_load  (result_load),
        .result_flags (result_flags),
        .result_mag   (result_mag)
    );

    iskscan_out #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (result_load),
        .load_flags    (result_flags),
        .load_mag      (result_mag),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_valid_reg && in_last_reg))
        else $error("result word without a final byte");

    a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && in_last_reg && m_axis_tvalid && !m_axis_tready)
        |=> (in_valid_reg && in_last_reg))
        else $error("final byte dropped while result stalled");

    a_sup_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[131:130] != 2'd3))
        else $error("bad supported code");

endmodule

/* tb/scan_result_checker.sv */
`timescale 1ns / 1ps

module scan_result_checker
    import iskscan_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    input  logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,   // text_byte
    input  logic                     s_axis_tlast,   // end_of_text
    input  logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // section_found, rank_value, rating_value, color_label_value,
    // pick_label_value, pick_label_seen, supported_state, zero pad
    input  logic [M_TDATA_WIDTH-1:0] m_axis_tdata,
    output int                       fail_count,
    output int                       outstanding
);

    localparam logic [63:0] CAP  = 64'd1 << (VALUE_WIDTH - 1);
    localparam logic [63:0] MASK = ((CAP - 64'd1) << 1) | 64'd1;

    typedef struct packed {
        logic        section_found;
        logic [31:0] rank_value;
        logic [31:0] rating_value;
        logic [31:0] color_label_value;
        logic [31:0] pick_label_value;
        logic        pick_label_seen;
        logic [1:0]  supported_state;
    } file_summary_t;

    file_summary_t  summary_q [$];

    iskscan_phase_t phase;
    logic           in_section;
    logic           section_seen;
    logic           scan_done;
    logic [4:0]     live_keys;
    logic [3:0]     pos;
    logic [2:0]     target;
    logic [63:0]    acc;
    logic           negative;
    logic [63:0]    num_store [NUM_KEY_COUNT];
    logic           pick_seen;
    logic [1:0]     supported;
    int             errors = 0;

    function automatic void reset_scan();
        phase        = PH_START;
        in_section   = 1'b0;
        section_seen = 1'b0;
        scan_done    = 1'b0;
        live_keys    = '1;
        pos          = '0;
        target       = KEY_RANK;
        acc          = '0;
        negative     = 1'b0;
        num_store[KEY_RANK[1:0]]        = MASK;
        num_store[KEY_RATING[1:0]]      = MASK;
        num_store[KEY_COLOR_LABEL[1:0]] = MASK;
        num_store[KEY_PICK_LABEL[1:0]]  = '0;
        pick_seen    = 1'b0;
        supported    = SUP_UNKNOWN;
    endfunction

    // saturated value of the running number into the current key
    function automatic void store_number();
        logic [63:0] v;
        if (negative)
        begin
            v = (acc > CAP) ? CAP : acc;
            v = (64'd0 - v) & MASK;
        end
        else
        begin
            v = (acc > CAP - 64'd1) ? CAP - 64'd1 : acc;
        end
        if (target < KEY_SUPPORTED)
            num_store[target[1:0]] = v;
    endfunction

    function automatic void add_digit(input logic [7:0] c);
        logic [63:0] d;
        d = 64'(c - CH_ZERO);
        if (acc >= CAP || acc > (CAP - d) / 64'd10)
            acc = CAP;
        else
            acc = acc * 64'd10 + d;
        store_number();
    endfunction

    function automatic void match_key(input logic [7:0] c);
        logic [4:0] nxt;
        int         k;
        nxt = '0;
        for (k = 0; k < KEY_COUNT; k++)
        begin
            if (live_keys[k])
            begin
                if (pos < KEY_LEN[k])
                begin
                    if (c == KEY_TEXT[k][pos])
                        nxt[k] = 1'b1;
                end
                else if (pos == KEY_LEN[k] && c == CH_EQUALS)
                begin
                    target = 3'(k);
                    if (target == KEY_SUPPORTED)
                    begin
                        supported = SUP_FALSE;
                        pos       = '0;
                        phase     = PH_TRUE;
                    end
                    else
                    begin
                        acc      = '0;
                        negative = 1'b0;
                        if (target == KEY_PICK_LABEL)
                            pick_seen = 1'b1;
                        store_number();
                        phase = PH_BLANK;
                    end
                    return;
                end
            end
        end
        live_keys = nxt;
        if (nxt != '0)
        begin
            if (pos < POS_MAX)
                pos++;
        end
        else
        begin
            phase = PH_SKIP;
        end
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        if (scan_done)
            return;
        if (c == CH_LF || c == CH_CR)
        begin
            phase = PH_START;
            return;
        end
        case (phase)
            PH_START:
            begin
                if (c == CH_LBRACK)
                begin
                    if (in_section)
                    begin
                        scan_done = 1'b1;
                        return;
                    end
                    pos   = 4'd1;
                    phase = PH_HEADER;
                end
                else if (in_section)
                begin
                    live_keys = '1;
                    pos       = '0;
                    phase     = PH_KEY;
                    match_key(c);
                end
                else
                begin
                    phase = PH_SKIP;
                end
            end
            PH_HEADER:
            begin
                if (pos < HDR_LEN && c == HDR_TEXT[pos])
                begin
                    pos++;
                    if (pos == HDR_LEN)
                    begin
                        in_section   = 1'b1;
                        section_seen = 1'b1;
                        phase        = PH_SKIP;
                    end
                end
                else
                begin
                    phase = PH_SKIP;
                end
            end
            PH_KEY:
                match_key(c);
            PH_BLANK:
            begin
                if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF)
                begin
                end
                else if (c == CH_PLUS || c == CH_MINUS)
                begin
                    negative = (c == CH_MINUS);
                    store_number();
                    phase = PH_DIGITS;
                end
                else if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    add_digit(c);
                    phase = PH_DIGITS;
                end
                else
                begin
                    phase = PH_SKIP;
                end
            end
            PH_DIGITS:
            begin
                if (c >= CH_ZERO && c <= CH_NINE)
                    add_digit(c);
                else
                    phase = PH_SKIP;
            end
            PH_TRUE:
            begin
                if (pos < TRUE_LEN && c == TRUE_TEXT[pos[1:0]])
                begin
                    pos++;
                    if (pos == TRUE_LEN)
                    begin
                        supported = SUP_TRUE;
                        phase     = PH_SKIP;
                    end
                end
                else
                begin
                    phase = PH_SKIP;
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic [31:0] to_out32(input logic [63:0] v);
        logic [63:0] s;
        s = v & MASK;
        if ((s & CAP) != '0)
            s = s | ~MASK;
        return s[31:0];
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        file_summary_t want;
        if (!rst_n)
        begin
            reset_scan();
            summary_q.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                scan_char(s_axis_tdata);
                if (s_axis_tlast)
                begin
                    want.section_found     = section_seen;
                    want.rank_value        = to_out32(num_store[KEY_RANK[1:0]]);
                    want.rating_value      = to_out32(num_store[KEY_RATING[1:0]]);
                    want.color_label_value = to_out32(num_store[KEY_COLOR_LABEL[1:0]]);
                    want.pick_label_value  = pick_seen
                                             ? to_out32(num_store[KEY_PICK_LABEL[1:0]])
                                             : 32'd0;
                    want.pick_label_seen   = pick_seen;
                    want.supported_state   = supported;
                    summary_q.insert(summary_q.size(), want);
                    reset_scan();
                end
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (summary_q.size() == 0)
                begin
                    errors++;
                    $error("result word with no file pending");
                end
                else
                begin
                    want = summary_q.pop_front();
                    check_field("section_found", 32'(want.section_found), 32'(m_axis_tdata[0]));
                    check_field("rank_value", want.rank_value, m_axis_tdata[32:1]);
                    check_field("rating_value", want.rating_value, m_axis_tdata[64:33]);
                    check_field("color_label_value", want.color_label_value,
                                m_axis_tdata[96:65]);
                    check_field("pick_label_value", want.pick_label_value,
                                m_axis_tdata[128:97]);
                    check_field("pick_label_seen", 32'(want.pick_label_seen),
                                32'(m_axis_tdata[129]));
                    check_field("supported_state", 32'(want.supported_state),
                                32'(m_axis_tdata[131:130]));
                    check_field("zero pad", 32'd0, 32'(m_axis_tdata[M_TDATA_WIDTH-1:132]));
                end
            end
        end
        fail_count  <= errors;
        outstanding <= summary_q.size();
    end

endmodule

/* tb/tb_ini_section_key_scanner.sv */
`timescale 1ns / 1ps

module tb_ini_section_key_scanner;
    import iskscan_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int BYTE_TARGET = 1450;

    localparam logic [7:0] BLANKS [4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [7:0]               s_axis_tdata;    // text_byte
    logic                     s_axis_tlast;    // end_of_text
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // section_found, rank_value, rating_value, color_label_value,
    // pick_label_value, pick_label_seen, supported_state, zero pad
    logic [M_TDATA_WIDTH-1:0] m_axis_tdata;

    int         fail_count;
    int         outstanding;
    logic       idle_en = 1'b1;
    int         stall_cycles = 0;
    int         bytes_sent = 0;
    int         files_sent = 0;
    logic [7:0] text_q [$];

    ini_section_key_scanner DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    scan_result_checker result_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
        m_axis_tready = !idle_en || $urandom_range(0, 99) >= 17;

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("ini_section_key_scanner test failed");
            $finish;
        end
    end

    function automatic void add_char(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endfunction

    function automatic void add_eol();
        case ($urandom_range(0, 4))
            0, 1: add_char(CH_LF);
            2: add_char(CH_CR);
            3:
            begin
                add_char(CH_CR);
                add_char(CH_LF);
            end
            default:
            begin
                add_char(CH_LF);
                add_char(CH_LF);
            end
        endcase
    endfunction

    function automatic void add_noise();
        repeat ($urandom_range(0, 8))
            add_char(8'($urandom_range(0, 255)));
    endfunction

    function automatic void add_header(input logic good);
        int j;
        for (j = 0; j < HDR_LEN; j++)
            add_char(HDR_TEXT[j]);
        if (!good)
        begin
            if ($urandom_range(0, 1) == 1)
                repeat ($urandom_range(1, HDR_LEN - 1))
                    void'(text_q.pop_back());
            else
                text_q[text_q.size() - $urandom_range(1, HDR_LEN - 1)] =
                    8'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 2) == 0)
            add_noise();
    endfunction

    function automatic void add_key_line();
        int          k;
        int          n;
        int          j;
        logic [63:0] v;
        string       s;
        k = $urandom_range(0, KEY_COUNT - 1);
        n = KEY_LEN[k];
        for (j = 0; j < n; j++)
            add_char(KEY_TEXT[k][j]);
        case ($urandom_range(0, 19))
            0: void'(text_q.pop_back());
            1: add_char(8'($urandom_range(33, 126)));
            2: text_q[text_q.size() - $urandom_range(1, n)] = 8'($urandom_range(0, 255));
            default:
            begin
            end
        endcase
        if ($urandom_range(0, 15) != 0)
            add_char(CH_EQUALS);
        if (k == KEY_SUPPORTED)
        begin
            case ($urandom_range(0, 3))
                0, 1: n = TRUE_LEN;
                2: n = $urandom_range(0, TRUE_LEN - 1);
                default: n = 0;
            endcase
            for (j = 0; j < n; j++)
                add_char(TRUE_TEXT[j]);
            if (n == 0 || $urandom_range(0, 2) == 0)
                add_noise();
        end
        else
        begin
            repeat ($urandom_range(0, 2))
                add_char(BLANKS[$urandom_range(0, 3)]);
            case ($urandom_range(0, 2))
                0: add_char(CH_PLUS);
                1: add_char(CH_MINUS);
                default:
                begin
                end
            endcase
            case ($urandom_range(0, 9))
                0:
                begin
                end
                1:
                begin
                    // around the 32-bit saturation points
                    v = (64'd1 << 31) - 64'd2 + 64'($urandom_range(0, 3));
                    s = $sformatf("%0d", v);
                    for (j = 0; j < s.len(); j++)
                        add_char(s[j]);
                end
                2:
                    repeat ($urandom_range(11, 20))
                        add_char(CH_ZERO + 8'($urandom_range(0, 9)));
                default:
                    repeat ($urandom_range(1, 10))
                        add_char(CH_ZERO + 8'($urandom_range(0, 9)));
            endcase
            if ($urandom_range(0, 3) == 0)
                add_noise();
        end
    endfunction

    function automatic void build_file();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                add_noise();
                add_eol();
            end
        end
        else
        begin
            repeat ($urandom_range(0, 2))
            begin
                case ($urandom_range(0, 2))
                    0: add_noise();
                    1: add_key_line();
                    default: add_header(1'b0);
                endcase
                add_eol();
            end
            add_header($urandom_range(0, 9) != 0);
            add_eol();
            repeat ($urandom_range(1, 5))
            begin
                if ($urandom_range(0, 4) == 0)
                    add_noise();
                else
                    add_key_line();
                add_eol();
            end
            // another header closes the section
            if ($urandom_range(0, 3) == 0)
            begin
                add_char(CH_LBRACK);
                add_noise();
                add_eol();
                add_key_line();
                add_eol();
            end
        end
        if ($urandom_range(0, 1) == 1)
            repeat ($urandom_range(1, 3))
                if (text_q.size() > 1)
                    void'(text_q.pop_back());
        if (text_q.size() == 0)
            add_char(8'($urandom_range(0, 255)));
    endfunction

    // entered and left at a falling edge
    task automatic put_byte(input logic [7:0] b, input logic last);
        if (idle_en && $urandom_range(0, 99) < 17)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 3))
                @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic send_file();
        int i;
        for (i = 0; i < text_q.size(); i++)
            put_byte(text_q[i], i == text_q.size() - 1);
        bytes_sent += text_q.size();
        files_sent++;
        text_q.delete();
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int j;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_char(8'h00);
        send_file();
        add_char(8'hff);
        send_file();
        add_char(CH_LBRACK);
        send_file();
        for (j = 0; j < HDR_LEN; j++)
            add_char(HDR_TEXT[j]);
        send_file();
        for (j = 0; j < HDR_LEN; j++)
            add_char(HDR_TEXT[j]);
        add_char(CH_LF);
        for (j = 0; j < KEY_LEN[KEY_RANK]; j++)
            add_char(KEY_TEXT[KEY_RANK][j]);
        add_char(CH_EQUALS);
        send_file();

        while (bytes_sent < BYTE_TARGET)
        begin
            idle_en = !(files_sent >= 12 && files_sent < 20);
            build_file();
            send_file();
            if (files_sent % 8 == 0)
                wait_drained();
        end

        idle_en = 1'b1;
        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("ini_section_key_scanner test passed");
        else
            $display("ini_section_key_scanner test failed");
        $finish;
    end

endmodule

/* ini_section_key_scanner.f */
sv/iskscan_pkg.sv
sv/iskscan_parse.sv
sv/iskscan_out.sv
sv/ini_section_key_scanner.sv
tb/scan_result_checker.sv
tb/tb_ini_section_key_scanner.sv
